/* design/scl_pkg.sv */
// ----------------------------------------------------------------------------
// scl_pkg
// Shared types and constants for the segmented chunk list manager.
// ----------------------------------------------------------------------------
package scl_pkg;

    localparam int SEGMENTS      = 64;
    localparam int TABLE_ENTRIES = 4096;

    localparam int SEG_W  = 6;                          // segment field width
    localparam int SEG_N  = 2 ** SEG_W;                 // pointer memory depth
    localparam int TAB_AW = $clog2(TABLE_ENTRIES);      // chunk table address
    localparam int PTR_W  = TAB_AW + 1;                 // pointer incl. empty code
    localparam int CMD_W  = 3;
    localparam int STS_W  = 3;
    localparam int CNT_W  = 32;
    localparam int OFS_W  = 48;
    localparam int IDX_W  = 12;

    typedef logic [PTR_W-1:0] ptr_t;
    localparam ptr_t PTR_NIL = '1;

    // commands
    localparam logic [CMD_W-1:0] CMD_WRITE      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READ       = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REWIND     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REWIND_ALL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_LENGTH     = 3'd5;

    // status codes
    localparam logic [STS_W-1:0] STS_OK    = 3'd0;
    localparam logic [STS_W-1:0] STS_END   = 3'd1;
    localparam logic [STS_W-1:0] STS_SMALL = 3'd2;
    localparam logic [STS_W-1:0] STS_FULL  = 3'd3;
    localparam logic [STS_W-1:0] STS_OVF   = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [SEG_W-1:0] segment;
        logic [CNT_W-1:0] byte_count;
    } scl_req_t;

    typedef struct packed {
        logic [STS_W-1:0] status;
        logic [OFS_W-1:0] chunk_offset;
        logic [CNT_W-1:0] chunk_length;
        logic [IDX_W-1:0] chunk_index;
        logic [OFS_W-1:0] segment_length;
    } scl_rsp_t;

    // one pointer memory word per segment
    typedef struct packed {
        ptr_t head;
        ptr_t tail;
        ptr_t rd;
    } seg_ent_t;

    // one chunk table word
    typedef struct packed {
        logic [OFS_W-1:0] offset;
        logic [CNT_W-1:0] length;
    } tab_ent_t;

    function automatic logic ptr_ok(ptr_t p);
        return int'(p) < TABLE_ENTRIES;
    endfunction

endpackage

/* design/segmented_chunk_list_manager_core.sv */
// ----------------------------------------------------------------------------
// segmented_chunk_list_manager_core
// Per-segment linked lists of chunk descriptors in a shared append-only table.
// ----------------------------------------------------------------------------
//
//  channel   ports                      timing
//  command   start, busy, request       taken when start & !busy
//  result    done, result               one cycle, cannot be held off
//
// The next command can be taken at the same edge that takes the result.
// Write, rewind, rewind all, clear and other commands: pointer memory read only.
// Read: pointer memory read, then chunk table read if a chunk is pending.
// Length query: pointer memory read, then one table read per chunk in the list.
// Reset clears the per-segment valid bits and counters at once; no sweep.
// busy is high from the cycle after the accept until done comes up.
//
module segmented_chunk_list_manager_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  scl_pkg::scl_req_t request,
    output logic              done,
    output scl_pkg::scl_rsp_t result
);
    import scl_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_SEG, ST_TAB, ST_WALK} state_t;

    state_t            state_reg, state_next;
    scl_req_t          req_reg, req_next;
    logic [SEG_N-1:0]  valid_reg, valid_next;
    logic [SEG_N-1:0]  rew_reg, rew_next;
    logic [OFS_W-1:0]  total_reg, total_next;
    ptr_t              used_reg, used_next;
    logic [OFS_W-1:0]  sum_reg, sum_next;
    ptr_t              walk_reg, walk_next;
    seg_ent_t          eff_reg, eff_next;
    scl_rsp_t          rsp_reg, rsp_next;
    logic              done_reg, done_next;

    // memories
    seg_ent_t          seg_mem [SEG_N];
    tab_ent_t          tab_mem [TABLE_ENTRIES];
    ptr_t              next_mem [TABLE_ENTRIES];
    seg_ent_t          seg_rd;
    tab_ent_t          tab_rd;
    ptr_t              next_rd;

    logic              seg_ren, seg_we;
    seg_ent_t          seg_wdata;
    logic              tab_ren, tab_we, next_we;
    ptr_t              tab_raddr, tab_waddr, next_waddr, next_wdata;
    tab_ent_t          tab_wdata;

    seg_ent_t          eff;
    logic              seg_ok;
    logic [OFS_W:0]    add_sum;
    logic [OFS_W-1:0]  walk_sum;

    assign busy    = (state_reg != ST_IDLE);
    assign done    = done_reg;
    assign result  = rsp_reg;
    assign seg_ren = start && !busy;

    always_ff @(posedge clk)
    begin
        if (seg_we)
        begin
            seg_mem[req_reg.segment] <= seg_wdata;
        end
        if (seg_ren)
        begin
            seg_rd <= seg_mem[request.segment];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            tab_mem[tab_waddr[TAB_AW-1:0]] <= tab_wdata;
        end
        if (next_we)
        begin
            next_mem[next_waddr[TAB_AW-1:0]] <= next_wdata;
        end
        if (tab_ren)
        begin
            tab_rd  <= tab_mem[tab_raddr[TAB_AW-1:0]];
            next_rd <= next_mem[tab_raddr[TAB_AW-1:0]];
        end
    end

    // Pointer word as seen after clear-all / rewind-all, which only touch flags.
    always_comb
    begin
        if (!valid_reg[req_reg.segment])
        begin
            eff = '{head: PTR_NIL, tail: PTR_NIL, rd: PTR_NIL};
        end
        else if (rew_reg[req_reg.segment])
        begin
            eff = '{head: seg_rd.head, tail: seg_rd.tail, rd: seg_rd.head};
        end
        else
        begin
            eff = seg_rd;
        end
    end

    assign seg_ok   = int'(req_reg.segment) < SEGMENTS;
    assign add_sum  = {1'b0, total_reg} + (OFS_W + 1)'(req_reg.byte_count);
    assign walk_sum = sum_reg + OFS_W'(tab_rd.length);

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        valid_next = valid_reg;
        rew_next   = rew_reg;
        total_next = total_reg;
        used_next  = used_reg;
        sum_next   = sum_reg;
        walk_next  = walk_reg;
        eff_next   = eff_reg;
        rsp_next   = rsp_reg;
        done_next  = 1'b0;

        seg_we     = 1'b0;
        seg_wdata  = eff;
        tab_ren    = 1'b0;
        tab_raddr  = eff.rd;
        tab_we     = 1'b0;
        tab_waddr  = used_reg;
        tab_wdata  = '{offset: total_reg, length: req_reg.byte_count};
        next_we    = 1'b0;
        next_waddr = eff.tail;
        next_wdata = used_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    state_next = ST_SEG;
                end
            end

            ST_SEG:
            begin
                rsp_next   = '0;
                done_next  = 1'b1;
                state_next = ST_IDLE;
                unique case (req_reg.command)
                    CMD_WRITE:
                    begin
                        if (req_reg.byte_count == '0 || !seg_ok)
                        begin
                            rsp_next.status = STS_OK;
                        end
                        else if (int'(used_reg) >= TABLE_ENTRIES)
                        begin
                            rsp_next.status = STS_FULL;
                        end
                        else if (add_sum[OFS_W])
                        begin
                            rsp_next.status = STS_OVF;
                        end
                        else
                        begin
                            tab_we = 1'b1;
                            seg_we = 1'b1;
                            if (ptr_ok(eff.head))
                            begin
                                next_we   = ptr_ok(eff.tail);
                                seg_wdata = '{head: eff.head, tail: used_reg, rd: eff.rd};
                            end
                            else
                            begin
                                seg_wdata = '{head: used_reg, tail: used_reg, rd: used_reg};
                            end
                            valid_next[req_reg.segment] = 1'b1;
                            rew_next[req_reg.segment]   = 1'b0;
                            total_next = add_sum[OFS_W-1:0];
                            used_next  = used_reg + 1'b1;
                            rsp_next.chunk_offset = total_reg;
                            rsp_next.chunk_length = req_reg.byte_count;
                            rsp_next.chunk_index  = IDX_W'(used_reg);
                        end
                    end
                    CMD_READ:
                    begin
                        if (!seg_ok || !ptr_ok(eff.rd))
                        begin
                            rsp_next.status = STS_END;
                        end
                        else
                        begin
                            tab_ren    = 1'b1;
                            walk_next  = eff.rd;
                            eff_next   = eff;
                            done_next  = 1'b0;
                            state_next = ST_TAB;
                        end
                    end
                    CMD_REWIND:
                    begin
                        if (seg_ok)
                        begin
                            seg_we    = 1'b1;
                            seg_wdata = '{head: eff.head, tail: eff.tail, rd: eff.head};
                            rew_next[req_reg.segment] = 1'b0;
                        end
                    end
                    CMD_REWIND_ALL:
                    begin
                        rew_next = '1;
                    end
                    CMD_CLEAR:
                    begin
                        valid_next = '0;
                        rew_next   = '0;
                        total_next = '0;
                        used_next  = '0;
                    end
                    CMD_LENGTH:
                    begin
                        if (seg_ok && ptr_ok(eff.head))
                        begin
                            tab_ren    = 1'b1;
                            tab_raddr  = eff.head;
                            walk_next  = eff.head;
                            sum_next   = '0;
                            eff_next   = eff;
                            done_next  = 1'b0;
                            state_next = ST_WALK;
                        end
                    end
                    default:
                    begin
                        rsp_next.status = STS_OK;
                    end
                endcase
            end

            ST_TAB:
            begin
                rsp_next              = '0;
                rsp_next.chunk_offset = tab_rd.offset;
                rsp_next.chunk_length = tab_rd.length;
                rsp_next.chunk_index  = IDX_W'(walk_reg);
                done_next             = 1'b1;
                state_next            = ST_IDLE;
                if (tab_rd.length > req_reg.byte_count)
                begin
                    rsp_next.status = STS_SMALL;
                end
                else
                begin
                    // tail entry's link word is stale: it always reads as end
                    seg_we    = 1'b1;
                    seg_wdata = '{head: eff_reg.head, tail: eff_reg.tail,
                                  rd: (walk_reg == eff_reg.tail) ? PTR_NIL : next_rd};
                    rew_next[req_reg.segment] = 1'b0;
                end
            end

            ST_WALK:
            begin
                if (walk_reg == eff_reg.tail)
                begin
                    rsp_next                = '0;
                    rsp_next.segment_length = walk_sum;
                    done_next               = 1'b1;
                    state_next              = ST_IDLE;
                end
                else
                begin
                    tab_ren   = 1'b1;
                    tab_raddr = next_rd;
                    walk_next = next_rd;
                    sum_next  = walk_sum;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            rew_reg   <= '0;
            total_reg <= '0;
            used_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            rew_reg   <= rew_next;
            total_reg <= total_next;
            used_reg  <= used_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        sum_reg  <= sum_next;
        walk_reg <= walk_next;
        eff_reg  <= eff_next;
        rsp_reg  <= rsp_next;
    end

endmodule

/* bench/segmented_chunk_list_manager_core_tb.sv */
// ----------------------------------------------------------------------------
// segmented_chunk_list_manager_core_tb
// Self-checking bench for the segmented chunk list manager. A scoreboard
// keeps its own copy of the per-segment lists and the chunk table, predicts
// one result word per accepted command and checks each done strobe against
// it. Directed corner cases come first, then weighted random traffic, then
// a few directed checks on the lists the random traffic leaves behind.
// ----------------------------------------------------------------------------
module segmented_chunk_list_manager_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scl_pkg::*;

    localparam int          RANDOM_WORDS = 1500;
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;

    // command codes the block ignores
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    class chunk_list_scoreboard;
        ptr_t             head_m [SEG_N];
        ptr_t             tail_m [SEG_N];
        ptr_t             rd_m   [SEG_N];
        logic [OFS_W-1:0] ofs_m  [TABLE_ENTRIES];
        logic [CNT_W-1:0] len_m  [TABLE_ENTRIES];
        ptr_t             next_m [TABLE_ENTRIES];
        logic [OFS_W-1:0] total_m;
        int unsigned      used_m;
        scl_rsp_t         expected_q[$];
        int unsigned      mismatches;

        function new();
            mismatches = 0;
            empty_lists();
        endfunction

        function void empty_lists();
            for (int s = 0; s < SEG_N; s++)
            begin
                head_m[s] = PTR_NIL;
                tail_m[s] = PTR_NIL;
                rd_m[s]   = PTR_NIL;
            end
            total_m = '0;
            used_m  = 0;
        endfunction

        function bit linked(ptr_t p);
            return int'(p) < TABLE_ENTRIES;
        endfunction

        // length of the chunk the next read of seg would return, zero if none
        function logic [CNT_W-1:0] pending_length(int unsigned seg);
            if (!linked(rd_m[seg]))
                return '0;
            return len_m[rd_m[seg]];
        endfunction

        function void note_failure(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t ns: mismatch: %s", $time, msg);
        endfunction

        // update the lists for an accepted command word and queue its result
        function void apply_command(scl_req_t word);
            scl_rsp_t         exp;
            ptr_t             p;
            logic [OFS_W-1:0] sum;
            int unsigned      steps;
            int unsigned      seg;
            bit               seg_in;
            exp    = '0;
            seg    = word.segment;
            seg_in = seg < SEGMENTS;
            exp.status = STS_OK;
            case (word.command)
                CMD_WRITE:
                begin
                    if (word.byte_count != 0 && seg_in)
                    begin
                        if (used_m >= TABLE_ENTRIES)
                            exp.status = STS_FULL;
                        else if ({16'd0, word.byte_count} > ({OFS_W{1'b1}} - total_m))
                            exp.status = STS_OVF;
                        else
                        begin
                            p         = ptr_t'(used_m);
                            ofs_m[p]  = total_m;
                            len_m[p]  = word.byte_count;
                            next_m[p] = PTR_NIL;
                            total_m   = total_m + word.byte_count;
                            used_m++;
                            if (!linked(head_m[seg]))
                            begin
                                head_m[seg] = p;
                                tail_m[seg] = p;
                                rd_m[seg]   = p;
                            end
                            else
                            begin
                                if (linked(tail_m[seg]))
                                    next_m[tail_m[seg]] = p;
                                tail_m[seg] = p;
                            end
                            exp.chunk_offset = ofs_m[p];
                            exp.chunk_length = len_m[p];
                            exp.chunk_index  = p[IDX_W-1:0];
                        end
                    end
                end
                CMD_READ:
                begin
                    if (!seg_in || !linked(rd_m[seg]))
                        exp.status = STS_END;
                    else
                    begin
                        p = rd_m[seg];
                        exp.chunk_offset = ofs_m[p];
                        exp.chunk_length = len_m[p];
                        exp.chunk_index  = p[IDX_W-1:0];
                        if (len_m[p] > word.byte_count)
                            exp.status = STS_SMALL;
                        else
                            rd_m[seg] = next_m[p];
                    end
                end
                CMD_REWIND:
                begin
                    if (seg_in)
                        rd_m[seg] = head_m[seg];
                end
                CMD_REWIND_ALL:
                begin
                    for (int s = 0; s < SEG_N; s++)
                        rd_m[s] = head_m[s];
                end
                CMD_CLEAR:
                    empty_lists();
                CMD_LENGTH:
                begin
                    if (seg_in)
                    begin
                        sum   = '0;
                        steps = 0;
                        p     = head_m[seg];
                        while (linked(p) && steps < TABLE_ENTRIES)
                        begin
                            sum = sum + len_m[p];
                            p   = next_m[p];
                            steps++;
                        end
                        exp.segment_length = sum;
                    end
                end
                default:
                    ;
            endcase
            expected_q = {expected_q, exp};
        endfunction

        function void check_result(scl_rsp_t got);
            scl_rsp_t exp;
            if (expected_q.size() == 0)
            begin
                note_failure($sformatf("result word with none expected, status %0d",
                                       got.status));
                return;
            end
            exp = expected_q.pop_front();
            if (got.status !== exp.status)
                note_failure($sformatf("status exp %0d got %0d", exp.status, got.status));
            if (got.chunk_offset !== exp.chunk_offset)
                note_failure($sformatf("chunk_offset exp %0h got %0h",
                                       exp.chunk_offset, got.chunk_offset));
            if (got.chunk_length !== exp.chunk_length)
                note_failure($sformatf("chunk_length exp %0h got %0h",
                                       exp.chunk_length, got.chunk_length));
            if (got.chunk_index !== exp.chunk_index)
                note_failure($sformatf("chunk_index exp %0d got %0d",
                                       exp.chunk_index, got.chunk_index));
            if (got.segment_length !== exp.segment_length)
                note_failure($sformatf("segment_length exp %0h got %0h",
                                       exp.segment_length, got.segment_length));
        endfunction
    endclass

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    scl_req_t request = '0;
    logic     done;
    scl_rsp_t result;

    chunk_list_scoreboard sb = new();
    bit                   burst = 1'b0;
    int unsigned          cycle_count = 0;

    segmented_chunk_list_manager_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.check_result(result);
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[segmented_chunk_list_manager_core] ERROR");
        $finish;
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int unsigned idle_cycles();
        int unsigned r;
        if (burst)
            return 0;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int unsigned pick_segment();
        if ($urandom_range(99) < 75)
            return $urandom_range(3);
        return $urandom_range(SEG_N - 1);
    endfunction

    function automatic logic [CNT_W-1:0] chunk_bytes();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5)
            return '0;
        if (r < 15)
            return '1;
        if (r < 45)
            return $urandom_range(1, 64);
        if (r < 70)
            return $urandom_range(1, 65536);
        return $urandom;
    endfunction

    // buffer sizes around the length of the chunk that would come back
    function automatic logic [CNT_W-1:0] read_capacity(int unsigned seg);
        logic [CNT_W-1:0] len;
        int unsigned      r;
        len = sb.pending_length(seg);
        r   = $urandom_range(99);
        if (r < 35)
            return '1;
        if (r < 55)
            return len;
        if (r < 70 && len != 0)
            return len - 1;
        if (r < 85)
            return $urandom;
        return $urandom_range(255);
    endfunction

    function automatic scl_req_t make_word(logic [CMD_W-1:0] cmd, int unsigned seg,
                                           logic [CNT_W-1:0] cnt);
        scl_req_t w;
        w.command    = cmd;
        w.segment    = seg[SEG_W-1:0];
        w.byte_count = cnt;
        return w;
    endfunction

    function automatic scl_req_t random_word();
        int unsigned seg;
        int unsigned r;
        seg = pick_segment();
        r   = $urandom_range(99);
        if (r < 40)
            return make_word(CMD_WRITE, seg, chunk_bytes());
        if (r < 74)
            return make_word(CMD_READ, seg, read_capacity(seg));
        if (r < 81)
            return make_word(CMD_REWIND, seg, $urandom);
        if (r < 84)
            return make_word(CMD_REWIND_ALL, seg, $urandom);
        if (r < 85)
            return make_word(CMD_CLEAR, seg, $urandom);
        if (r < 97)
            return make_word(CMD_LENGTH, seg, $urandom);
        return make_word(r[0] ? CMD_SPARE_7 : CMD_SPARE_6, seg, $urandom);
    endfunction

    // called at a rising edge; returns at the edge that accepts the word
    task automatic send_word(input scl_req_t word, input int unsigned gap);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= word;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.apply_command(word);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        send_word(make_word(CMD_READ, 0, '1), idle_cycles());
        send_word(make_word(CMD_LENGTH, 0, '0), idle_cycles());
        send_word(make_word(CMD_WRITE, 0, 32'd1), idle_cycles());
        send_word(make_word(CMD_WRITE, 63, '1), idle_cycles());
        send_word(make_word(CMD_WRITE, 0, '0), idle_cycles());
        send_word(make_word(CMD_WRITE, 0, 32'd100), idle_cycles());
        send_word(make_word(CMD_LENGTH, 0, '1), idle_cycles());
        send_word(make_word(CMD_READ, 0, '0), idle_cycles());
        send_word(make_word(CMD_READ, 0, 32'd1), idle_cycles());
        send_word(make_word(CMD_READ, 0, 32'd99), idle_cycles());
        send_word(make_word(CMD_READ, 0, 32'd100), idle_cycles());
        send_word(make_word(CMD_READ, 0, '1), idle_cycles());
        // appended after the read pointer ran off the end: still end of list
        send_word(make_word(CMD_WRITE, 0, 32'd5), idle_cycles());
        send_word(make_word(CMD_READ, 0, '1), idle_cycles());
        send_word(make_word(CMD_REWIND, 0, '0), idle_cycles());
        send_word(make_word(CMD_READ, 0, '1), idle_cycles());
        send_word(make_word(CMD_READ, 63, 32'hFFFF_FFFE), idle_cycles());
        send_word(make_word(CMD_READ, 63, '1), idle_cycles());
        send_word(make_word(CMD_REWIND_ALL, 42, '0), idle_cycles());
        send_word(make_word(CMD_SPARE_6, 21, 32'hA5A5_A5A5), idle_cycles());
        send_word(make_word(CMD_SPARE_7, 42, 32'h5A5A_5A5A), idle_cycles());
        send_word(make_word(CMD_CLEAR, 63, '1), idle_cycles());
        send_word(make_word(CMD_READ, 63, '1), idle_cycles());
        send_word(make_word(CMD_LENGTH, 63, '0), idle_cycles());
        wait_drained();
        @(posedge clk);

        // random traffic
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if ($urandom_range(99) < 3)
                burst = !burst;
            send_word(random_word(), idle_cycles());
            if ($urandom_range(99) < 2)
                wait_drained();
        end
        burst = 1'b0;

        // directed checks on whatever lists the random traffic left
        send_word(make_word(CMD_WRITE, 0, '0), idle_cycles());
        for (int s = 0; s < 4; s++)
        begin
            send_word(make_word(CMD_LENGTH, s, '0), idle_cycles());
            send_word(make_word(CMD_READ, s, '1), idle_cycles());
            send_word(make_word(CMD_READ, s, read_capacity(s)), idle_cycles());
        end
        send_word(make_word(CMD_REWIND_ALL, 0, '0), idle_cycles());
        send_word(make_word(CMD_READ, 1, '1), idle_cycles());
        send_word(make_word(CMD_CLEAR, 0, '0), idle_cycles());
        send_word(make_word(CMD_WRITE, 5, 32'd77), idle_cycles());
        send_word(make_word(CMD_READ, 5, '1), idle_cycles());
        send_word(make_word(CMD_LENGTH, 5, '0), idle_cycles());

        wait_drained();
        repeat (8) @(posedge clk);
        if (sb.expected_q.size() != 0)
            sb.note_failure($sformatf("%0d result words missing", sb.expected_q.size()));
        if (sb.mismatches == 0)
            $display("[segmented_chunk_list_manager_core] OK");
        else
            $display("[segmented_chunk_list_manager_core] ERROR");
        $finish;
    end

endmodule

/* sim.f */
design/scl_pkg.sv
design/segmented_chunk_list_manager_core.sv
bench/segmented_chunk_list_manager_core_tb.sv
